[design/ahma_pkg.sv]
package ahma_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int FRAC_BITS         = 16;
  localparam int HEADING_W         = 12;
  localparam int MAGNITUDE_W       = 11;
  localparam int THR_W             = 16;
  localparam int THR_SQ_W          = 2 * THR_W;

  localparam logic [THR_W-1:0] THR_RESET = 16'd7680;

  // angle units: 1/65536 tenth of a degree
  localparam int ANGLE_W   = 30;
  localparam int FULL_TURN = 3600 * (1 << FRAC_BITS);
  localparam int HALF_TURN = 1800 * (1 << FRAC_BITS);
  localparam logic [HEADING_W-1:0] TENTHS_WRAP = 12'd3600;

  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd29491200;
      1:  v = 32'd17409672;
      2:  v = 32'd9198793;
      3:  v = 32'd4669451;
      4:  v = 32'd2343786;
      5:  v = 32'd1173036;
      6:  v = 32'd586661;
      7:  v = 32'd293348;
      8:  v = 32'd146676;
      9:  v = 32'd73339;
      10: v = 32'd36669;
      11: v = 32'd18335;
      12: v = 32'd9167;
      13: v = 32'd4584;
      14: v = 32'd2292;
      15: v = 32'd1146;
      16: v = 32'd573;
      17: v = 32'd286;
      18: v = 32'd143;
      19: v = 32'd72;
      20: v = 32'd36;
      21: v = 32'd18;
      22: v = 32'd9;
      23: v = 32'd4;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[design/ahma_sample_if.sv]
interface ahma_sample_if #(
  parameter int SAMPLE_WIDTH = ahma_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

[design/ahma_result_if.sv]
interface ahma_result_if;
  logic        valid;
  logic        ready;
  logic [11:0] heading_tenths;
  logic [10:0] magnitude_tenths;
  logic        abnormal;

  modport source (output valid, heading_tenths, magnitude_tenths, abnormal, input ready);
  modport sink (input valid, heading_tenths, magnitude_tenths, abnormal, output ready);
endinterface

[design/ahma_cfg_if.sv]
interface ahma_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[design/accel_heading_magnitude_alarm.sv]
// the heading path (CORDIC_STAGES rotations, capped at 24) and the magnitude path are padded to equal depth,
// which at the defaults is set by the one-bit-per-stage square root pipeline
// throughput: one beat per cycle; the whole pipeline holds while the result is stalled
// reset: pipeline emptied, threshold returns to 7680; config beats always taken
module accel_heading_magnitude_alarm #(
  parameter int SAMPLE_WIDTH  = ahma_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = ahma_pkg::CORDIC_STAGES_DEF
) (
  input logic            clk,
  input logic            rst,
  ahma_sample_if.sink    sample,
  ahma_result_if.source  result,
  ahma_cfg_if.sink       cfg
);
  import ahma_pkg::*;

  localparam int NST   = CORDIC_STAGES < ATAN_ENTRIES ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int LAT_H = NST + 2;
  localparam int LAT_M = SAMPLE_WIDTH + 10;
  localparam int L     = LAT_H > LAT_M ? LAT_H : LAT_M;

  logic [THR_W-1:0]    thr;
  logic [THR_SQ_W-1:0] thr_sq;
  logic [L-1:0]        vld;
  logic                adv;

  assign cfg.ready    = 1'b1;
  assign adv          = !vld[L-1] || result.ready;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_RESET;
      thr_sq <= THR_SQ_W'(THR_RESET) * THR_SQ_W'(THR_RESET);
      vld    <= '0;
    end else begin
      if (cfg.valid) begin
        thr <= cfg.data;
      end
      thr_sq <= thr * thr;
      if (adv) begin
        vld <= {vld[L-2:0], sample.valid};
      end
    end
  end

  ahma_heading #(
    .SW  (SAMPLE_WIDTH),
    .NST (NST),
    .LAT (L)
  ) u_heading (
    .clk     (clk),
    .en      (adv),
    .x       (sample.accel_x),
    .y       (sample.accel_y),
    .heading (result.heading_tenths)
  );

  ahma_magnitude #(
    .SW  (SAMPLE_WIDTH),
    .LAT (L)
  ) u_magnitude (
    .clk       (clk),
    .en        (adv),
    .x         (sample.accel_x),
    .y         (sample.accel_y),
    .z         (sample.accel_z),
    .thr_sq    (thr_sq),
    .magnitude (result.magnitude_tenths),
    .abnormal  (result.abnormal)
  );

  assign result.valid = vld[L-1];
endmodule

[design/ahma_heading.sv]
module ahma_heading #(
  parameter int SW  = ahma_pkg::SAMPLE_WIDTH_DEF,
  parameter int NST = ahma_pkg::CORDIC_STAGES_DEF,
  parameter int LAT = ahma_pkg::CORDIC_STAGES_DEF + 2
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [SW-1:0]                x,
  input  logic signed [SW-1:0]                y,
  output logic        [ahma_pkg::HEADING_W-1:0] heading
);
  import ahma_pkg::*;

  localparam int XW  = SW + 19;
  localparam int PAD = LAT - NST - 2;

  logic signed [XW-1:0]      cx [NST+1];
  logic signed [XW-1:0]      cy [NST+1];
  logic signed [ANGLE_W-1:0] cz [NST+1];
  logic                      zf [NST+1];

  logic signed [XW-1:0] xe, ye;
  logic                 neg;

  assign xe  = XW'(x);
  assign ye  = XW'(y);
  assign neg = x[SW-1];

  // fold left half plane by a half turn
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= (neg ? -xe : xe) <<< FRAC_BITS;
      cy[0] <= (neg ? -ye : ye) <<< FRAC_BITS;
      cz[0] <= neg ? ANGLE_W'(HALF_TURN) : '0;
      zf[0] <= (x == '0) && (y == '0);
    end
  end

  for (genvar i = 0; i < NST; i++) begin : g_rot
    localparam logic signed [ANGLE_W-1:0] ATAN = ANGLE_W'(atan_entry(i));
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end
      end
    end
  end

  logic signed [ANGLE_W-1:0] zw;
  logic        [ANGLE_W-1:0] zr;
  logic        [HEADING_W-1:0] tenths;

  always_comb begin
    zw     = cz[NST][ANGLE_W-1] ? cz[NST] + ANGLE_W'(FULL_TURN) : cz[NST];
    zr     = unsigned'(zw) + ANGLE_W'(1 << (FRAC_BITS - 1));
    tenths = zr[FRAC_BITS +: HEADING_W];
    if (tenths == TENTHS_WRAP || zf[NST]) begin
      tenths = '0;
    end
  end

  logic [HEADING_W-1:0] hd [PAD+1];

  always_ff @(posedge clk) begin
    if (en) begin
      hd[0] <= tenths;
    end
  end

  for (genvar k = 1; k <= PAD; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        hd[k] <= hd[k-1];
      end
    end
  end

  assign heading = hd[PAD];
endmodule

[design/ahma_magnitude.sv]
module ahma_magnitude #(
  parameter int SW  = ahma_pkg::SAMPLE_WIDTH_DEF,
  parameter int LAT = ahma_pkg::SAMPLE_WIDTH_DEF + 10
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [SW-1:0]                  x,
  input  logic signed [SW-1:0]                  y,
  input  logic signed [SW-1:0]                  z,
  input  logic [ahma_pkg::THR_SQ_W-1:0]         thr_sq,
  output logic [ahma_pkg::MAGNITUDE_W-1:0]      magnitude,
  output logic                                  abnormal
);
  import ahma_pkg::*;

  localparam int SSW = 2 * SW + 2;
  localparam int NW  = 2 * SW + 10;
  localparam int RW  = NW / 2;
  localparam int CW  = SSW > THR_SQ_W ? SSW : THR_SQ_W;
  localparam int PAD = LAT - RW - 5;

  logic [SW-1:0]    ax, ay, az;
  logic [2*SW-1:0]  qx, qy, qz;
  logic [SSW-1:0]   s2, s3;
  logic [NW-1:0]    n3;

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= x[SW-1] ? unsigned'(SW'(-x)) : unsigned'(x);
      ay <= y[SW-1] ? unsigned'(SW'(-y)) : unsigned'(y);
      az <= z[SW-1] ? unsigned'(SW'(-z)) : unsigned'(z);
      qx <= ax * ax;
      qy <= ay * ay;
      qz <= az * az;
      s2 <= SSW'(qx) + SSW'(qy) + SSW'(qz);
      s3 <= s2;
      // 100 * s as shifts and adds
      n3 <= (NW'(s2) << 6) + (NW'(s2) << 5) + (NW'(s2) << 2);
    end
  end

  logic [RW+1:0]  rem  [RW+1];
  logic [RW-1:0]  root [RW+1];
  logic [NW-1:0]  nsh  [RW+1];
  logic [SSW-1:0] sp   [RW+1];

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign nsh[0]  = n3;
  assign sp[0]   = s3;

  // one result bit of floor(sqrt(100 s)) per stage
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RW+3:0] rin, trial, diff;
    assign rin   = {rem[k], nsh[k][NW-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign diff  = rin - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        nsh[k+1] <= nsh[k] << 2;
        sp[k+1]  <= sp[k];
        if (rin >= trial) begin
          rem[k+1]  <= diff[RW+1:0];
          root[k+1] <= {root[k][RW-2:0], 1'b1};
        end else begin
          rem[k+1]  <= rin[RW+1:0];
          root[k+1] <= {root[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  logic [RW:0]          rsum;
  logic [RW-9:0]        mq;
  logic [MAGNITUDE_W-1:0] mag;

  always_comb begin
    rsum = {1'b0, root[RW]} + (RW+1)'(256);
    mq   = rsum[RW:9];
    mag  = (mq > (RW-8)'({MAGNITUDE_W{1'b1}})) ? {MAGNITUDE_W{1'b1}} : mq[MAGNITUDE_W-1:0];
  end

  logic [MAGNITUDE_W-1:0] md [PAD+1];
  logic                   ab [PAD+1];

  always_ff @(posedge clk) begin
    if (en) begin
      md[0] <= mag;
      ab[0] <= CW'(sp[RW]) > CW'(thr_sq);
    end
  end

  for (genvar k = 1; k <= PAD; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        md[k] <= md[k-1];
        ab[k] <= ab[k-1];
      end
    end
  end

  assign magnitude = md[PAD];
  assign abnormal  = ab[PAD];
endmodule
